[hw/rtl/swk_pkg.sv]
`default_nettype none
// ============================================================================
// swk_pkg: shared types and constants of the sliding-window kappa block
// Field widths, configuration register indexes, request codes, the Q2.14
// constants and the status bundle of the shared divider.
// ============================================================================
package swk_pkg;

    localparam int LABEL_W   = 4;
    localparam int KAPPA_W   = 16;
    localparam int MATCH_W   = 11;
    localparam int WSIZE_W   = 11;
    localparam int CCOUNT_W  = 5;
    localparam int CFG_IDX_W = 1;
    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 32;

    // Q2.14 fraction bits and the number of quotient bits the divider returns.
    localparam int Q14_FRAC = 14;
    localparam int QB       = Q14_FRAC + 1;

    localparam logic signed [KAPPA_W-1:0] Q14_ONE = 16'sd16384;

    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SIZE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_CLASS_COUNT = 1'b1;

    localparam logic [WSIZE_W-1:0]  WSIZE_RESET  = 11'd1024;
    localparam logic [CCOUNT_W-1:0] CCOUNT_RESET = 5'd2;

    localparam logic REQ_PUSH  = 1'b0;
    localparam logic REQ_CLEAR = 1'b1;

    typedef struct packed {
        logic done;
        logic ovf;
    } div_status_t;

endpackage
`default_nettype wire

[hw/rtl/swk_ram.sv]
`default_nettype none
// ============================================================================
// swk_ram: generic single-port-write, single-port-read RAM
// One write and one read per cycle; the read data is registered.
// ============================================================================
module swk_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

[hw/rtl/swk_div.sv]
`default_nettype none
// ============================================================================
// swk_div: restoring divider, one quotient bit per cycle
// Returns QB quotient bits and flags overflow when the quotient does not fit.
// ============================================================================
module swk_div #(
    parameter int DW = 38
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      start,
    input  wire logic [DW-1:0]             dividend,
    input  wire logic [DW-1:0]             divisor,
    output swk_pkg::div_status_t           status,
    output logic      [swk_pkg::QB-1:0]    quotient
);

    import swk_pkg::*;

    localparam int CNTW = $clog2(QB + 1);

    logic [DW-1:0]   rem_reg;
    logic [DW-1:0]   dsr_reg;
    logic [QB-1:0]   quo_reg;
    logic [CNTW-1:0] cnt_reg;
    logic            busy_reg;
    logic            done_reg;
    logic            ovf_reg;
    logic            fits;

    assign fits = (rem_reg >= dsr_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNTW'(QB);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNTW'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= dividend;
            dsr_reg <= divisor << (QB - 1);
            quo_reg <= '0;
            // The quotient must stay below 2^QB for the bit loop to be exact.
            ovf_reg <= (dividend >= (divisor << QB));
        end else if (busy_reg) begin
            if (fits) begin
                rem_reg <= rem_reg - dsr_reg;
            end
            quo_reg <= {quo_reg[QB-2:0], fits};
            dsr_reg <= dsr_reg >> 1;
        end
    end

    assign status.done = done_reg;
    assign status.ovf  = ovf_reg;
    assign quotient    = quo_reg;

endmodule
`default_nettype wire

[hw/rtl/sliding_window_kappa.sv]
`default_nettype none
// ============================================================================
// sliding_window_kappa: Cohen's kappa over a sliding window of label pairs
// Ring memory of label pairs, per-class counts, one shared multiplier and a
// bit-serial divider under a one-hot sequencer.
// ============================================================================
// The block takes one request at a time and drops s_tready until its result
// is in the output register. A clear request goes straight to the output
// state. A push evicts the oldest pair while the window is full, inserts
// its pair and, if the window is then short of full, goes to the output
// state. A push that fills the window then forms the product sum over the
// classes in use (the effective class count) on the one multiplier, forms
// numerator and denominator and runs the one-bit-per-cycle divider. Each
// eviction passes through a check state and an update state because the
// ring memory returns its read data in the cycle after the address. No
// clearing pass is needed after reset; only ring entries written since
// the last clear are ever read.
// ============================================================================
module sliding_window_kappa #(
    parameter int MAX_WINDOW  = 1024,
    parameter int MAX_CLASSES = 16
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // Request stream.
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // s_tdata: true label [3:0], predicted label [7:4]
    input  wire logic [swk_pkg::S_TDATA_W-1:0]     s_tdata,
    // s_tuser: req_type [0]
    input  wire logic [0:0]                        s_tuser,
    // Result stream.
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // m_tdata: kappa_q14 [15:0], match_count [26:16], zero [31:27]
    output logic      [swk_pkg::M_TDATA_W-1:0]     m_tdata,
    // m_tuser: window_full [0]
    output logic      [0:0]                        m_tuser,
    // Configuration writes.
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [swk_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [swk_pkg::WSIZE_W-1:0]       cfg_data
);

    import swk_pkg::*;

    localparam int AW = $clog2(MAX_WINDOW);
    localparam int CW = $clog2(MAX_WINDOW + 1);
    localparam int IW = $clog2(MAX_CLASSES);
    localparam int KW = $clog2(MAX_CLASSES + 1);
    localparam int PW = 2 * CW;
    localparam int DW = PW + Q14_FRAC + 2;

    localparam logic [CW:0]   MAXW_EXT = (CW + 1)'(MAX_WINDOW);
    localparam logic [AW-1:0] WP_LAST  = AW'(MAX_WINDOW - 1);

    typedef enum logic [11:0] {
        S_IDLE    = 12'b0000_0000_0001,
        S_EVCHK   = 12'b0000_0000_0010,
        S_EVUPD   = 12'b0000_0000_0100,
        S_INSERT  = 12'b0000_0000_1000,
        S_SUM     = 12'b0000_0001_0000,
        S_MNC     = 12'b0000_0010_0000,
        S_MNN     = 12'b0000_0100_0000,
        S_DIFF    = 12'b0000_1000_0000,
        S_DIVGO   = 12'b0001_0000_0000,
        S_DIVWAIT = 12'b0010_0000_0000,
        S_OUT     = 12'b0100_0000_0000,
        S_SPARE   = 12'b1000_0000_0000
    } state_t;

    function automatic logic lbl_ok(input logic [LABEL_W-1:0] lbl);
        return (32'(lbl) < MAX_CLASSES);
    endfunction

    state_t state_reg, state_next;

    logic [WSIZE_W-1:0]  window_size_reg;
    logic [CCOUNT_W-1:0] classes_reg;

    logic [LABEL_W-1:0]  act_reg;
    logic [LABEL_W-1:0]  pred_reg;
    logic [AW-1:0]       wp_reg;
    logic [CW-1:0]       fill_reg;
    logic [CW-1:0]       correct_reg;
    logic [CW-1:0]       row_cnt_reg [MAX_CLASSES];
    logic [CW-1:0]       col_cnt_reg [MAX_CLASSES];

    logic [KW-1:0]       k_reg;
    logic [PW-1:0]       prod_reg;
    logic                prod_vld_reg;
    logic [PW-1:0]       acc_reg;
    logic [PW-1:0]       ncp_reg;
    logic                neg_reg;
    logic [PW-1:0]       mag_reg;
    logic [PW-1:0]       den_reg;

    logic signed [KAPPA_W-1:0] kappa_res_reg;
    logic                      full_res_reg;
    logic                      m_tvalid_reg;
    logic [M_TDATA_W-1:0]      m_tdata_reg;
    logic                      m_tuser_reg;

    logic [CW-1:0]       w_eff;
    logic [KW-1:0]       nc_eff;
    logic [CW:0]         oldest_sum;
    logic [AW-1:0]       oldest_addr;
    logic [7:0]          ram_rdata;
    logic [LABEL_W-1:0]  ev_act;
    logic [LABEL_W-1:0]  ev_pred;
    logic [IW-1:0]       row_addr;
    logic [IW-1:0]       col_addr;
    logic [CW-1:0]       row_rd;
    logic [CW-1:0]       col_rd;
    logic [CW-1:0]       mul_a;
    logic [CW-1:0]       mul_b;
    logic [PW-1:0]       mul_out;
    logic signed [PW:0]  num_diff;
    logic                ins_full;
    logic                s_accept;
    logic                out_free;
    logic                div_start;
    logic [DW-1:0]       div_dividend;
    logic [DW-1:0]       div_divisor;
    div_status_t         div_st;
    logic [QB-1:0]       div_quo;
    logic [KAPPA_W-1:0]  q_mag;

    // ------------------------------------------------------------------
    // Configuration registers and their effective values.
    // ------------------------------------------------------------------
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_size_reg <= WSIZE_RESET;
            classes_reg     <= CCOUNT_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_WINDOW_SIZE: window_size_reg <= cfg_data;
                CFG_CLASS_COUNT: classes_reg     <= cfg_data[CCOUNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (window_size_reg == '0) begin
            w_eff = CW'(1);
        end else if (32'(window_size_reg) > MAX_WINDOW) begin
            w_eff = CW'(MAX_WINDOW);
        end else begin
            w_eff = CW'(window_size_reg);
        end
        if (classes_reg < CCOUNT_W'(2)) begin
            nc_eff = KW'(2);
        end else if (32'(classes_reg) > MAX_CLASSES) begin
            nc_eff = KW'(MAX_CLASSES);
        end else begin
            nc_eff = KW'(classes_reg);
        end
    end

    // ------------------------------------------------------------------
    // Handshakes and sequencer.
    // ------------------------------------------------------------------
    assign s_tready = (state_reg == S_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign ins_full = (CW'(fill_reg + 1'b1) == w_eff);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_accept) begin
                    state_next = (s_tuser[0] == REQ_CLEAR) ? S_OUT : S_EVCHK;
                end
            end
            S_EVCHK:   state_next = (fill_reg >= w_eff) ? S_EVUPD : S_INSERT;
            S_EVUPD:   state_next = S_EVCHK;
            S_INSERT:  state_next = ins_full ? S_SUM : S_OUT;
            S_SUM:     state_next = (k_reg == nc_eff) ? S_MNC : S_SUM;
            S_MNC:     state_next = S_MNN;
            S_MNN:     state_next = S_DIFF;
            S_DIFF:    state_next = S_DIVGO;
            S_DIVGO:   state_next = (den_reg == '0) ? S_OUT : S_DIVWAIT;
            S_DIVWAIT: state_next = div_st.done ? S_OUT : S_DIVWAIT;
            S_OUT:     state_next = out_free ? S_IDLE : S_OUT;
            default:   state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // ------------------------------------------------------------------
    // Ring of label pairs: actual in the high nibble, predicted in the low.
    // ------------------------------------------------------------------
    // Oldest entry sits fill_reg places behind the write pointer.
    assign oldest_sum  = (CW + 1)'(wp_reg) + MAXW_EXT - (CW + 1)'(fill_reg);
    assign oldest_addr = (oldest_sum >= MAXW_EXT) ? AW'(oldest_sum - MAXW_EXT)
                                                  : AW'(oldest_sum);

    swk_ram #(
        .WIDTH(2 * LABEL_W),
        .DEPTH(MAX_WINDOW)
    ) u_ring (
        .aclk (aclk),
        .we   (state_reg == S_INSERT),
        .waddr(wp_reg),
        .wdata({act_reg, pred_reg}),
        .raddr(oldest_addr),
        .rdata(ram_rdata)
    );

    assign ev_act  = ram_rdata[2*LABEL_W-1:LABEL_W];
    assign ev_pred = ram_rdata[LABEL_W-1:0];

    // ------------------------------------------------------------------
    // Per-class counts, read through one address per table per cycle.
    // ------------------------------------------------------------------
    always_comb begin
        case (state_reg)
            S_SUM: begin
                row_addr = k_reg[IW-1:0];
                col_addr = k_reg[IW-1:0];
            end
            S_EVUPD: begin
                row_addr = IW'(ev_act);
                col_addr = IW'(ev_pred);
            end
            default: begin
                row_addr = IW'(act_reg);
                col_addr = IW'(pred_reg);
            end
        endcase
    end

    assign row_rd = row_cnt_reg[row_addr];
    assign col_rd = col_cnt_reg[col_addr];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg      <= '0;
            fill_reg    <= '0;
            correct_reg <= '0;
            for (int i = 0; i < MAX_CLASSES; i++) begin
                row_cnt_reg[i] <= '0;
                col_cnt_reg[i] <= '0;
            end
        end else begin
            case (state_reg)
                S_IDLE: begin
                    if (s_accept && (s_tuser[0] == REQ_CLEAR)) begin
                        wp_reg      <= '0;
                        fill_reg    <= '0;
                        correct_reg <= '0;
                        for (int i = 0; i < MAX_CLASSES; i++) begin
                            row_cnt_reg[i] <= '0;
                            col_cnt_reg[i] <= '0;
                        end
                    end
                end
                S_EVUPD: begin
                    if (lbl_ok(ev_act) && (row_rd != '0)) begin
                        row_cnt_reg[row_addr] <= row_rd - 1'b1;
                    end
                    if (lbl_ok(ev_pred) && (col_rd != '0)) begin
                        col_cnt_reg[col_addr] <= col_rd - 1'b1;
                    end
                    if ((ev_act == ev_pred) && (correct_reg != '0)) begin
                        correct_reg <= correct_reg - 1'b1;
                    end
                    fill_reg <= fill_reg - 1'b1;
                end
                S_INSERT: begin
                    if (lbl_ok(act_reg)) begin
                        row_cnt_reg[row_addr] <= row_rd + 1'b1;
                    end
                    if (lbl_ok(pred_reg)) begin
                        col_cnt_reg[col_addr] <= col_rd + 1'b1;
                    end
                    if (act_reg == pred_reg) begin
                        correct_reg <= correct_reg + 1'b1;
                    end
                    fill_reg <= fill_reg + 1'b1;
                    wp_reg   <= (wp_reg == WP_LAST) ? '0 : wp_reg + 1'b1;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            act_reg  <= s_tdata[LABEL_W-1:0];
            pred_reg <= s_tdata[2*LABEL_W-1:LABEL_W];
        end
    end

    // ------------------------------------------------------------------
    // Shared multiplier: class products, then N*C and N*N.
    // ------------------------------------------------------------------
    always_comb begin
        case (state_reg)
            S_SUM: begin
                mul_a = row_rd;
                mul_b = col_rd;
            end
            S_MNC: begin
                mul_a = fill_reg;
                mul_b = correct_reg;
            end
            S_MNN: begin
                mul_a = fill_reg;
                mul_b = fill_reg;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_out  = mul_a * mul_b;
    assign num_diff = $signed({1'b0, ncp_reg}) - $signed({1'b0, acc_reg});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prod_vld_reg <= 1'b0;
            k_reg        <= '0;
        end else begin
            case (state_reg)
                S_INSERT: begin
                    prod_vld_reg <= 1'b0;
                    k_reg        <= '0;
                end
                S_SUM: begin
                    // Products are accumulated in the cycle after they are formed.
                    if (k_reg < nc_eff) begin
                        prod_vld_reg <= 1'b1;
                        k_reg        <= k_reg + 1'b1;
                    end else begin
                        prod_vld_reg <= 1'b0;
                    end
                end
                default: prod_vld_reg <= 1'b0;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            S_INSERT: acc_reg <= '0;
            S_SUM: begin
                if (prod_vld_reg) begin
                    acc_reg <= acc_reg + prod_reg;
                end
                if (k_reg < nc_eff) begin
                    prod_reg <= mul_out;
                end
            end
            S_MNC: prod_reg <= mul_out;
            S_MNN: begin
                ncp_reg  <= prod_reg;
                prod_reg <= mul_out;
            end
            S_DIFF: begin
                neg_reg <= num_diff[PW];
                mag_reg <= num_diff[PW] ? PW'(-num_diff) : PW'(num_diff);
                den_reg <= prod_reg - acc_reg;
            end
            default: ;
        endcase
    end

    // ------------------------------------------------------------------
    // Rounded division: floor((2*|num|*2^14 + den) / (2*den)).
    // ------------------------------------------------------------------
    assign div_start    = (state_reg == S_DIVGO) && (den_reg != '0);
    assign div_dividend = (DW'(mag_reg) << (Q14_FRAC + 1)) + DW'(den_reg);
    assign div_divisor  = DW'(den_reg) << 1;

    swk_div #(
        .DW(DW)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .dividend(div_dividend),
        .divisor (div_divisor),
        .status  (div_st),
        .quotient(div_quo)
    );

    assign q_mag = (div_st.ovf || (div_quo > QB'(Q14_ONE))) ? Q14_ONE
                                                            : KAPPA_W'(div_quo);

    always_ff @(posedge aclk) begin
        case (state_reg)
            S_IDLE: begin
                kappa_res_reg <= '0;
                full_res_reg  <= 1'b0;
            end
            S_INSERT: begin
                kappa_res_reg <= '0;
                full_res_reg  <= ins_full;
            end
            S_DIVGO: begin
                if (den_reg == '0) begin
                    kappa_res_reg <= Q14_ONE;
                end
            end
            S_DIVWAIT: begin
                if (div_st.done) begin
                    kappa_res_reg <= neg_reg ? -$signed(q_mag) : $signed(q_mag);
                end
            end
            default: ;
        endcase
    end

    // ------------------------------------------------------------------
    // Output register.
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if ((state_reg == S_OUT) && out_free) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if ((state_reg == S_OUT) && out_free) begin
            m_tdata_reg <= M_TDATA_W'({MATCH_W'(correct_reg), kappa_res_reg});
            m_tuser_reg <= full_res_reg;
        end
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;
    assign m_tuser[0] = m_tuser_reg;

`ifndef ASSERT_OFF
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (fill_reg <= CW'(MAX_WINDOW)) && (correct_reg <= fill_reg))
        else $error("window fill or match count out of range");

    a_out_from_seq: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && !$past(m_tvalid_reg)) |-> ($past(state_reg) == S_OUT))
        else $error("result appeared outside the output state");

    a_div_done: assert property (@(posedge aclk) disable iff (!aresetn)
        div_st.done |-> (state_reg == S_DIVWAIT))
        else $error("divider finished while the sequencer was not waiting");

    a_sum_index: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SUM) |-> (k_reg <= nc_eff))
        else $error("class index ran past the classes in use");
`endif

endmodule
`default_nettype wire
